// ===== rtl/core/irclt_pkg.sv =====
// ----------------------------------------------------------------------------
// irclt_pkg
// Shared types, character codes and the per-byte line step of the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package irclt_pkg;

    localparam int MAX_LINE   = 512;
    localparam int MAX_PARAMS = 15;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [9:0] LEN_SAT = 10'd1023;
    localparam logic [4:0] CNT_SAT = 5'd31;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    localparam logic [1:0] KIND_CMD    = 2'd0;
    localparam logic [1:0] KIND_MIDDLE = 2'd1;
    localparam logic [1:0] KIND_TRAIL  = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_TOO_LONG  = 3'd1;
    localparam logic [2:0] STAT_ZERO_BYTE = 3'd2;
    localparam logic [2:0] STAT_NO_SPACE  = 3'd3;
    localparam logic [2:0] STAT_TOO_MANY  = 3'd4;

    typedef enum logic [3:0] {
        PH_START  = 4'b0001,
        PH_PREFIX = 4'b0010,
        PH_BODY   = 4'b0100,
        PH_TRAIL  = 4'b1000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic        pending_cr;
        logic        pending_space;
        logic        inside_token;
        logic [4:0]  token_counter;
        logic [9:0]  line_length;
        logic        seen_zero_byte;
        logic        seen_command;
    } line_state_t;

    localparam line_state_t LINE_CLEAR = '{
        phase: PH_START, pending_cr: 1'b0, pending_space: 1'b0,
        inside_token: 1'b0, token_counter: 5'd0, line_length: 10'd0,
        seen_zero_byte: 1'b0, seen_command: 1'b0
    };

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       token_start;
        logic [4:0] token_number;
        logic [2:0] line_status;
        logic       has_trailing;
        logic [4:0] param_count;
    } result_t;

    typedef struct packed {
        line_state_t st;
        logic        valid;
        result_t     res;
    } byte_step_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
               (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    endfunction

    // One byte that belongs to the line: new state and at most one result.
    function automatic byte_step_t line_byte(input line_state_t st_in, input logic [7:0] b);
        byte_step_t  r;
        line_state_t s;
        logic        done;
        logic [7:0]  ob;
        s        = st_in;
        r.valid  = 1'b0;
        r.res    = '0;
        done     = 1'b0;
        ob       = b;
        if (s.line_length != LEN_SAT)
            s.line_length = s.line_length + 10'd1;
        if (b == CH_NUL)
            s.seen_zero_byte = 1'b1;

        if (s.phase == PH_START) begin
            if (b == CH_COLON) begin
                s.phase = PH_PREFIX;
                done    = 1'b1;
            end else begin
                s.phase = PH_BODY;
            end
        end

        if (!done) begin
            if (s.phase == PH_PREFIX) begin
                if (b == CH_SPACE) begin
                    s.phase         = PH_BODY;
                    s.pending_space = 1'b0;
                end
            end else if (s.phase == PH_TRAIL) begin
                r.valid           = 1'b1;
                r.res.out_byte    = b;
                r.res.kind        = KIND_TRAIL;
                r.res.token_start = ~s.inside_token;
                s.inside_token    = 1'b1;
            end else if (b == CH_COLON && s.pending_space) begin
                // space-colon opens the trailing part
                s.phase         = PH_TRAIL;
                s.pending_space = 1'b0;
                s.inside_token  = 1'b0;
            end else begin
                s.pending_space = (b == CH_SPACE);
                if (is_ws(b)) begin
                    s.inside_token = 1'b0;
                end else begin
                    if (!s.inside_token) begin
                        r.res.token_start = 1'b1;
                        s.inside_token    = 1'b1;
                        if (!s.seen_command)
                            s.seen_command = 1'b1;
                        else if (s.token_counter != CNT_SAT)
                            s.token_counter = s.token_counter + 5'd1;
                    end
                    r.valid = 1'b1;
                    if (s.token_counter == 5'd0) begin
                        r.res.kind         = KIND_CMD;
                        r.res.token_number = 5'd0;
                        if (b >= CH_LO_A && b <= CH_LO_Z)
                            ob = b - CASE_GAP;
                    end else begin
                        r.res.kind         = KIND_MIDDLE;
                        r.res.token_number = s.token_counter;
                    end
                    r.res.out_byte = ob;
                end
            end
        end
        r.st = s;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/irclt_parse.sv =====
// ----------------------------------------------------------------------------
// irclt_parse
// Line state and the combinational byte step; yields up to two results a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module irclt_parse #(
    parameter int MaxLine   = irclt_pkg::MAX_LINE,
    parameter int MaxParams = irclt_pkg::MAX_PARAMS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [7:0]          byte_in,
    output logic [1:0]               push_cnt,
    output irclt_pkg::result_t       res_a,
    output irclt_pkg::result_t       res_b
);

    localparam logic [9:0] LEN_LIMIT = 10'(MaxLine - 2);
    localparam logic [4:0] PAR_LIMIT = 5'(MaxParams);

    irclt_pkg::line_state_t line_st_reg;
    irclt_pkg::line_state_t line_st_next;
    irclt_pkg::line_state_t mid_st;
    irclt_pkg::byte_step_t  cr_step;
    irclt_pkg::byte_step_t  cur_step;
    irclt_pkg::result_t     end_res;
    logic                   trail;
    logic                   line_done;

    // held CR replayed as a line byte first
    always_comb
    begin
        mid_st            = line_st_reg;
        mid_st.pending_cr = 1'b0;
        cr_step           = irclt_pkg::line_byte(mid_st, irclt_pkg::CH_CR);
        if (!line_st_reg.pending_cr)
        begin
            cr_step.st    = mid_st;
            cr_step.valid = 1'b0;
        end
        cur_step = irclt_pkg::line_byte(cr_step.st, byte_in);
        if (byte_in == irclt_pkg::CH_CR)
        begin
            cur_step.st            = cr_step.st;
            cur_step.st.pending_cr = 1'b1;
            cur_step.valid         = 1'b0;
        end
    end

    always_comb
    begin
        trail                = (line_st_reg.phase == irclt_pkg::PH_TRAIL);
        end_res              = '0;
        end_res.kind         = irclt_pkg::KIND_END;
        end_res.has_trailing = trail;
        end_res.param_count  = line_st_reg.token_counter;
        if (line_st_reg.line_length > LEN_LIMIT)
            end_res.line_status = irclt_pkg::STAT_TOO_LONG;
        else if (line_st_reg.seen_zero_byte)
            end_res.line_status = irclt_pkg::STAT_ZERO_BYTE;
        else if (line_st_reg.phase == irclt_pkg::PH_PREFIX)
            end_res.line_status = irclt_pkg::STAT_NO_SPACE;
        else if (!trail && line_st_reg.token_counter > PAR_LIMIT)
            end_res.line_status = irclt_pkg::STAT_TOO_MANY;
        else
            end_res.line_status = irclt_pkg::STAT_OK;
    end

    assign line_done = line_st_reg.pending_cr && (byte_in == irclt_pkg::CH_LF);

    always_comb
    begin
        if (line_done)
        begin
            line_st_next = irclt_pkg::LINE_CLEAR;
            push_cnt     = 2'd1;
            res_a        = end_res;
            res_b        = end_res;
        end
        else
        begin
            line_st_next = cur_step.st;
            push_cnt     = 2'({1'b0, cr_step.valid} + {1'b0, cur_step.valid});
            res_a        = cr_step.valid ? cr_step.res : cur_step.res;
            res_b        = cur_step.res;
        end
        if (!step)
            push_cnt = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_st_reg <= irclt_pkg::LINE_CLEAR;
        else if (step)
            line_st_reg <= line_st_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/irclt_res_fifo.sv =====
// ----------------------------------------------------------------------------
// irclt_res_fifo
// Small result queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module irclt_res_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [1:0]          push_cnt,
    input  wire irclt_pkg::result_t  push_a,
    input  wire irclt_pkg::result_t  push_b,
    input  wire logic                pop,
    output logic                     not_empty,
    output logic                     has_room,
    output irclt_pkg::result_t       head
);

    localparam int AW = irclt_pkg::FIFO_AW;
    localparam int CW = AW + 1;

    irclt_pkg::result_t mem [irclt_pkg::FIFO_DEPTH];

    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] wr_ptr_b;
    logic          do_pop;

    assign wr_ptr_b  = wr_ptr_reg + AW'(1);
    assign not_empty = (count_reg != '0);
    // room for a two-result beat
    assign has_room  = (count_reg <= CW'(irclt_pkg::FIFO_DEPTH - 2));
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem[wr_ptr_reg] <= push_a;
        if (push_cnt == 2'd2)
            mem[wr_ptr_b] <= push_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + AW'(push_cnt);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            count_reg <= count_reg + CW'(push_cnt) - CW'(do_pop);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/irc_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// irc_line_tokenizer
// Streaming IRC line tokenizer: input register, byte step, result queue.
// ----------------------------------------------------------------------------
// An accepted byte waits in the input register; its results are then written to the queue.
// Throughput: one byte per cycle; a byte gives zero, one or two results, and
// the output side drains one result per cycle from a four-entry queue.
// Input stalls while the queue holds more than two results.
// Reset (rst_n low, asynchronous) clears line state, input stage and queue.
`default_nettype none

module irc_line_tokenizer #(
    parameter int MaxLine   = irclt_pkg::MAX_LINE,
    parameter int MaxParams = irclt_pkg::MAX_PARAMS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic [1:0]       kind,
    output logic             token_start,
    output logic [4:0]       token_number,
    output logic [2:0]       line_status,
    output logic             has_trailing,
    output logic [4:0]       param_count
);

    logic               byte_valid_reg;
    logic [7:0]         byte_reg;
    logic               step;
    logic               has_room;
    logic [1:0]         push_cnt;
    irclt_pkg::result_t res_a;
    irclt_pkg::result_t res_b;
    irclt_pkg::result_t head;

    assign step     = byte_valid_reg && has_room;
    assign in_ready = !byte_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_valid_reg <= 1'b0;
        else if (in_ready)
            byte_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            byte_reg <= in_byte;
    end

    irclt_parse #(
        .MaxLine   (MaxLine),
        .MaxParams (MaxParams)
    ) u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .byte_in  (byte_reg),
        .push_cnt (push_cnt),
        .res_a    (res_a),
        .res_b    (res_b)
    );

    irclt_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_a    (res_a),
        .push_b    (res_b),
        .pop       (out_ready),
        .not_empty (out_valid),
        .has_room  (has_room),
        .head      (head)
    );

    assign out_byte     = head.out_byte;
    assign kind         = head.kind;
    assign token_start  = head.token_start;
    assign token_number = head.token_number;
    assign line_status  = head.line_status;
    assign has_trailing = head.has_trailing;
    assign param_count  = head.param_count;

endmodule

`default_nettype wire
